// ----- rtl/core/bfaa_pkg.sv -----
// Shared types, constants and helper functions for the bitmap free-address
// allocator core. No dependencies.
package bfaa_pkg;

    localparam int NUM_GROUPS      = 32;   // live groups, 1..32
    localparam int MAX_GROUPS      = 32;   // table rows, fixed by the 8-bit address
    localparam int SLOTS_PER_GROUP = 8;
    localparam int GROUP_W         = 5;
    localparam int SLOT_W          = 3;
    localparam int ADDR_W          = GROUP_W + SLOT_W;
    localparam int GROUP_CNT_W     = GROUP_W + 1;

    localparam logic [MAX_GROUPS-1:0] LIVE_GROUPS =
        (NUM_GROUPS >= MAX_GROUPS) ? {MAX_GROUPS{1'b1}}
                                   : MAX_GROUPS'((64'd1 << NUM_GROUPS) - 64'd1);

    typedef enum logic {
        REQ_ALLOC   = 1'b0,
        REQ_RELEASE = 1'b1
    } req_type_t;

    typedef logic [MAX_GROUPS-1:0]                          group_mask_t;
    typedef logic [SLOTS_PER_GROUP-1:0]                     slot_row_t;
    typedef logic [MAX_GROUPS-1:0][SLOTS_PER_GROUP-1:0]     slot_table_t;

    // Outcome of the lowest-free search for one allocate.
    typedef struct packed {
        logic               found;    // a free slot was located
        logic               repair;   // group bit set but its row empty
        logic               emptied;  // group has no free slot after this grant
        logic [GROUP_W-1:0] grp;
        logic [SLOT_W-1:0]  slot;
    } pick_t;

    function automatic logic [GROUP_W-1:0] lowest_group(input group_mask_t m);
        logic [GROUP_W-1:0] idx;
        idx = GROUP_W'(MAX_GROUPS - 1);
        for (int i = MAX_GROUPS - 1; i >= 0; i--) begin
            if (m[i]) idx = GROUP_W'(i);
        end
        return idx;
    endfunction

    function automatic logic [SLOT_W-1:0] lowest_slot(input slot_row_t r);
        logic [SLOT_W-1:0] idx;
        idx = SLOT_W'(SLOTS_PER_GROUP - 1);
        for (int i = SLOTS_PER_GROUP - 1; i >= 0; i--) begin
            if (r[i]) idx = SLOT_W'(i);
        end
        return idx;
    endfunction

endpackage

// ----- rtl/core/bfaa_select.sv -----
// Lowest-free address search: priority encode the group mask, then the
// chosen group's slot row. Uses bfaa_pkg.
module bfaa_select
    import bfaa_pkg::*;
(
    input  group_mask_t group_free,
    input  slot_table_t slot_free,
    output pick_t       pick
);

    group_mask_t        groups;
    logic [GROUP_W-1:0] grp;
    slot_row_t          row;
    logic [SLOT_W-1:0]  slot;
    slot_row_t          row_after;

    always_comb begin
        groups    = group_free & LIVE_GROUPS;
        grp       = lowest_group(groups);
        row       = slot_free[grp];
        slot      = lowest_slot(row);
        row_after = row & ~(slot_row_t'(1) << slot);

        pick.grp     = grp;
        pick.slot    = slot;
        pick.found   = (groups != '0) && (row != '0);
        pick.repair  = (groups != '0) && (row == '0);
        pick.emptied = (row_after == '0);
    end

endmodule

// ----- rtl/core/bitmap_free_address_allocator_core.sv -----
// Top level of the bitmap free-address allocator core.
// Depends on bfaa_pkg and bfaa_select.
//
// Usage
//   Input channel (s_valid/s_ready): one request item. s_req_type = 0 asks
//   for the lowest free address; s_req_type = 1 returns s_release_addr to
//   the pool. Result channel (m_valid/m_ready): exactly one item per
//   request, m_granted_addr plus m_no_free.
//   Allocate: lowest free group first, then lowest free slot in it. An empty
//   pool gives address 0 with m_no_free = 1 and leaves the pool alone.
//   Release: the address is echoed with m_no_free = 0; releasing a free
//   address or one above the live groups leaves the pool unchanged.
// Timing
//   Two register stages: an input register and a result register. Throughput
//   is one item per cycle while m_ready stays high; the read-modify-write of
//   the group mask and one slot row at the moment an item moves to the result
//   register is what allows the very next item to see the updated pool.
// Reset
//   aresetn (synchronous, active low) empties both stages and marks every
//   address free: group mask all ones over the live groups, slot rows all
//   ones. The pool is usable on the first cycle after reset.
// Backpressure
//   While m_ready is low the result holds; one more item can wait in the
//   input register, after which s_ready drops.
module bitmap_free_address_allocator_core
    import bfaa_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_req_type,
    input  logic [ADDR_W-1:0] s_release_addr,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [ADDR_W-1:0] m_granted_addr,
    output logic              m_no_free
);

    // input stage
    logic              in_valid_reg;
    req_type_t         in_req_reg;
    logic [ADDR_W-1:0] in_addr_reg;

    // result stage
    logic              out_valid_reg;
    logic [ADDR_W-1:0] out_addr_reg;
    logic              out_no_free_reg;

    // pool state
    group_mask_t group_free_reg, group_free_next;
    slot_table_t slot_free_reg,  slot_free_next;

    logic              advance;
    logic              s_accept;
    pick_t             pick;
    logic [GROUP_W-1:0] rel_grp;
    logic [SLOT_W-1:0]  rel_slot;
    logic              rel_live;
    logic [ADDR_W-1:0] res_addr;
    logic              res_no_free;

    // an item moves from input to result register when the result slot frees
    assign advance  = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready  = !in_valid_reg || advance;
    assign s_accept = s_valid && s_ready;

    assign m_valid        = out_valid_reg;
    assign m_granted_addr = out_addr_reg;
    assign m_no_free      = out_no_free_reg;

    bfaa_select u_select (
        .group_free (group_free_reg),
        .slot_free  (slot_free_reg),
        .pick       (pick)
    );

    assign rel_grp  = in_addr_reg[ADDR_W-1:SLOT_W];
    assign rel_slot = in_addr_reg[SLOT_W-1:0];
    assign rel_live = GROUP_CNT_W'(rel_grp) < GROUP_CNT_W'(NUM_GROUPS);

    // pool update and result for the item in the input register
    always_comb begin
        group_free_next = group_free_reg;
        slot_free_next  = slot_free_reg;
        res_addr        = '0;
        res_no_free     = 1'b0;
        case (in_req_reg)
            REQ_ALLOC: begin
                if (pick.found) begin
                    slot_free_next[pick.grp][pick.slot] = 1'b0;
                    if (pick.emptied) group_free_next[pick.grp] = 1'b0;
                    res_addr = {pick.grp, pick.slot};
                end else begin
                    // empty pool, or a set group bit whose row is empty
                    if (pick.repair) group_free_next[pick.grp] = 1'b0;
                    res_no_free = 1'b1;
                end
            end
            REQ_RELEASE: begin
                if (rel_live) begin
                    group_free_next[rel_grp]          = 1'b1;
                    slot_free_next[rel_grp][rel_slot] = 1'b1;
                end
                res_addr = in_addr_reg;
            end
            default: begin
                res_addr = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            group_free_reg <= LIVE_GROUPS;
            slot_free_reg  <= '1;
        end else begin
            if (s_accept) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end

            if (advance) begin
                out_valid_reg  <= 1'b1;
                group_free_reg <= group_free_next;
                slot_free_reg  <= slot_free_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_req_reg  <= req_type_t'(s_req_type);
            in_addr_reg <= s_release_addr;
        end
        if (advance) begin
            out_addr_reg    <= res_addr;
            out_no_free_reg <= res_no_free;
        end
    end

    // row-not-empty summary, checked against the group mask
    group_mask_t row_nonempty;
    always_comb begin
        for (int g = 0; g < MAX_GROUPS; g++) begin
            row_nonempty[g] = (slot_free_reg[g] != '0);
        end
    end

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------

    // the two bitmap levels agree on every live group
    a_levels_agree: assert property (@(posedge aclk) disable iff (!aresetn)
        (group_free_reg & LIVE_GROUPS) == (row_nonempty & LIVE_GROUPS))
        else $error("group mask disagrees with slot rows");

    // a granted address is marked used on the next cycle
    a_grant_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && in_req_reg == REQ_ALLOC && pick.found) |=>
        !slot_free_reg[$past(pick.grp)][$past(pick.slot)])
        else $error("granted slot still marked free");

    // an empty report carries address zero
    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_no_free) |-> (m_granted_addr == '0))
        else $error("no_free result with nonzero address");

    // the input stage never stalls while the result stage can take its item
    a_no_bubble: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && (!out_valid_reg || m_ready)) |-> s_ready)
        else $error("input held while result stage free");

endmodule

// ----- sim/alloc_result_checker.sv -----
// Result checker for the bitmap free-address allocator core: mirrors the pool,
// predicts each grant or echo and compares it with the result channel.
// Depends on bfaa_pkg.
module alloc_result_checker
    import bfaa_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic              s_ready,
    input  logic              s_req_type,
    input  logic [ADDR_W-1:0] s_release_addr,
    input  logic              m_valid,
    input  logic              m_ready,
    input  logic [ADDR_W-1:0] m_granted_addr,
    input  logic              m_no_free,
    output int                fail_count,
    output int                outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic              no_free;
    } grant_t;

    // mirror of the pool
    group_mask_t free_groups;
    slot_table_t free_slots;
    grant_t      grants_due[$];
    int          mismatches = 0;

    // Apply one request to the mirrored pool and return the result it owes.
    function automatic grant_t serve_request(input req_type_t req,
                                             input logic [ADDR_W-1:0] addr);
        grant_t             res;
        group_mask_t        live;
        logic [GROUP_W-1:0] grp;
        logic [SLOT_W-1:0]  slot;
        logic               hit;
        res  = '0;
        grp  = '0;
        slot = '0;
        hit  = 1'b0;
        if (req == REQ_ALLOC) begin
            live = free_groups & LIVE_GROUPS;
            for (int i = 0; i < MAX_GROUPS; i++) begin
                if (!hit && live[i]) begin
                    hit = 1'b1;
                    grp = GROUP_W'(i);
                end
            end
            if (!hit) begin
                res.no_free = 1'b1;
            end else if (free_slots[grp] == '0) begin
                // levels disagree: drop the stale group bit, report empty
                free_groups[grp] = 1'b0;
                res.no_free      = 1'b1;
            end else begin
                hit = 1'b0;
                for (int i = 0; i < SLOTS_PER_GROUP; i++) begin
                    if (!hit && free_slots[grp][i]) begin
                        hit  = 1'b1;
                        slot = SLOT_W'(i);
                    end
                end
                free_slots[grp][slot] = 1'b0;
                if (free_slots[grp] == '0)
                    free_groups[grp] = 1'b0;
                res.addr = {grp, slot};
            end
        end else begin
            grp  = addr[ADDR_W-1:SLOT_W];
            slot = addr[SLOT_W-1:0];
            if (int'(grp) < NUM_GROUPS) begin
                free_groups[grp]      = 1'b1;
                free_slots[grp][slot] = 1'b1;
            end
            res.addr = addr;
        end
        return res;
    endfunction

    task automatic note_failure(input string msg);
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
            $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    always @(posedge aclk) begin : watch
        grant_t want;
        if (!aresetn) begin
            free_groups = LIVE_GROUPS;
            free_slots  = '1;
            grants_due.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (grants_due.size() == 0) begin
                    note_failure($sformatf("unexpected item addr=%0d no_free=%0b",
                                           m_granted_addr, m_no_free));
                end else begin
                    want = grants_due.pop_front();
                    if (m_granted_addr !== want.addr)
                        note_failure($sformatf("granted_addr expected %0d got %0d",
                                               want.addr, m_granted_addr));
                    if (m_no_free !== want.no_free)
                        note_failure($sformatf("no_free expected %0b got %0b",
                                               want.no_free, m_no_free));
                end
            end
            if (s_valid && s_ready)
                grants_due.push_back(serve_request(req_type_t'(s_req_type),
                                                   s_release_addr));
        end
        fail_count  <= mismatches;
        outstanding <= grants_due.size();
    end

endmodule

// ----- sim/tb_bitmap_free_address_allocator_core.sv -----
// Testbench top for the bitmap free-address allocator core: drives requests,
// random backpressure, a long result stall, and prints the verdict.
// Depends on bfaa_pkg, alloc_result_checker and the core RTL.
module tb_bitmap_free_address_allocator_core;
    timeunit 1ns;
    timeprecision 1ps;
    import bfaa_pkg::*;

    localparam int IDLE_PCT       = 38;    // chance of an idle cycle on either side
    localparam int CALM_FROM      = 500;   // no idling from this item count ...
    localparam int CALM_TO        = 700;   // ... up to this one
    localparam int STALL_AT       = 80;    // results taken before the long hold-off
    localparam int STALL_CYCLES   = 300;   // length of the hold-off
    localparam int WATCHDOG_LIMIT = 2000;  // quiet cycles before giving up
    localparam int DRAIN_CYCLES   = 10;    // settling time after the checker has no item outstanding
    localparam int FILL_ITEMS     = 270;   // more than the pool holds
    localparam int SEGMENTS       = 17;
    localparam int SEG_ITEMS      = 40;

    logic              aclk           = 1'b0;
    logic              aresetn        = 1'b0;
    logic              s_valid        = 1'b0;
    logic              s_ready;
    logic              s_req_type     = REQ_ALLOC;
    logic [ADDR_W-1:0] s_release_addr = '0;
    logic              m_valid;
    logic              m_ready        = 1'b0;
    logic [ADDR_W-1:0] m_granted_addr;
    logic              m_no_free;

    int fail_count;
    int outstanding;
    int sent  = 0;   // input items accepted
    int quiet = 0;   // cycles since the last handshake

    always #5 aclk = ~aclk;

    bitmap_free_address_allocator_core uut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_req_type     (s_req_type),
        .s_release_addr (s_release_addr),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_granted_addr (m_granted_addr),
        .m_no_free      (m_no_free)
    );

    alloc_result_checker checker_i (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_req_type     (s_req_type),
        .s_release_addr (s_release_addr),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_granted_addr (m_granted_addr),
        .m_no_free      (m_no_free),
        .fail_count     (fail_count),
        .outstanding    (outstanding)
    );

    // Offer one request and hold it until the core takes it. Random idle
    // cycles go in front of it, except inside the calm window. Returns on
    // the edge that accepted the item, so the caller drives the next one in
    // the same step without touching s_valid twice.
    task automatic send_req(input req_type_t req, input logic [ADDR_W-1:0] addr);
        while (!(sent >= CALM_FROM && sent < CALM_TO) &&
               $urandom_range(0, 99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_req_type     <= req;
        s_release_addr <= addr;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sent++;
    endtask

    // Allocates carry a random address too: the core must ignore it.
    task automatic send_alloc();
        send_req(REQ_ALLOC, ADDR_W'($urandom));
    endtask

    // Releases split between the whole range and the low end, where the
    // lowest-first policy keeps most of the held addresses, so holes appear.
    task automatic send_release();
        if ($urandom_range(0, 1) == 0)
            send_req(REQ_RELEASE, ADDR_W'($urandom_range(0, 255)));
        else
            send_req(REQ_RELEASE, ADDR_W'($urandom_range(0, 47)));
    endtask

    // Result side: random backpressure, a calm window, and one long hold-off
    // that lets the core fill both stages and drop s_ready while the sender
    // keeps offering.
    initial begin : result_side
        int  taken;
        bit  stalled;
        taken   = 0;
        stalled = 1'b0;
        @(posedge aclk iff aresetn);
        forever begin
            if (taken == STALL_AT && !stalled) begin
                stalled = 1'b1;
                m_ready <= 1'b0;
                repeat (STALL_CYCLES) @(posedge aclk);
            end
            m_ready <= (taken >= CALM_FROM && taken < CALM_TO) ||
                       ($urandom_range(0, 99) >= IDLE_PCT);
            @(posedge aclk);
            if (m_valid && m_ready) taken++;
        end
    end

    // Watchdog: too long without any item moving on either channel.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet <= 0;
        end else if (quiet >= WATCHDOG_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    initial begin : stimulus
        int pct;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: lowest-first order, hole refill, release of a free address,
        // both address extremes, and allocates carrying all-ones/all-zeros
        // in the ignored address field.
        send_req(REQ_ALLOC, 8'hFF);        // 0
        send_req(REQ_ALLOC, 8'h00);        // 1
        send_alloc();                      // 2
        send_alloc();                      // 3
        send_req(REQ_RELEASE, 8'd1);       // hole at 1
        send_alloc();                      // refills 1
        send_req(REQ_RELEASE, 8'd255);     // top address, already free
        send_req(REQ_RELEASE, 8'd0);       // bottom address, held
        send_req(REQ_RELEASE, 8'd0);       // same again, now free
        send_alloc();                      // 0 again
        send_req(REQ_RELEASE, 8'hAA);      // free, echoed only
        send_alloc();                      // 4
        send_req(REQ_RELEASE, 8'd3);
        send_req(REQ_RELEASE, 8'd2);
        send_alloc();                      // 2
        send_alloc();                      // 3
        send_req(REQ_RELEASE, 8'h55);

        // Exhaust the pool: the tail of this run hits the empty-pool case.
        repeat (FILL_ITEMS) send_alloc();

        // Random segments, each with its own allocate share, so the pool
        // swings between nearly empty and full and grants come from holes.
        for (int seg = 0; seg < SEGMENTS; seg++) begin
            case ($urandom_range(0, 4))
                0:       pct = 5;
                1:       pct = 25;
                2:       pct = 50;
                3:       pct = 75;
                default: pct = 95;
            endcase
            repeat (SEG_ITEMS) begin
                if ($urandom_range(0, 99) < pct)
                    send_alloc();
                else
                    send_release();
            end
        end
        s_valid <= 1'b0;

        // Drain: the watchdog covers a result that never comes. One edge
        // first so the count includes the last item sent.
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (fail_count == 0 && outstanding == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
